// ===== rtl/pf_pkg.sv =====
// Package for the prime factorizer.
// Holds field widths, the default value width and the sequencer state codes.
// No dependencies.
package pf_pkg;

    localparam int VALUE_BITS_DEF = 16;
    localparam int NUMBER_W       = 16;
    localparam int EXP_W          = 4;
    localparam int FIRST_DIVISOR  = 2;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_CHECK = 6'b000010,
        ST_DIV   = 6'b000100,
        ST_EMIT  = 6'b001000,
        ST_NEXT  = 6'b010000,
        ST_TAIL  = 6'b100000
    } pf_state_t;

endpackage

// ===== rtl/prime_factorizer.sv =====
// The time from input to first result depends on the factors; each trial
// divisor is tested on the shared divider, and trial divisors run from 2 up
// to the square root of the remaining value. One item at a time; in_ready is
// high only while the sequencer is idle. Reset is asynchronous, active low,
// and clears the sequencer, the divider control and the output valid.
// Top level: trial-division sequencer and result register around pf_divider.
// Depends on pf_pkg and pf_divider.
module prime_factorizer
    import pf_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [NUMBER_W-1:0] number,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [NUMBER_W-1:0] prime,
    output logic [EXP_W-1:0]    exponent,
    output logic                last,
    output logic                invalid
);

    localparam int SQW = VALUE_BITS + 2;

    pf_state_t             state_reg, state_next;
    logic                  out_valid_reg, out_valid_next;

    logic [VALUE_BITS-1:0] rem_reg, rem_next;
    logic [VALUE_BITS-1:0] div_reg, div_next;
    logic [SQW-1:0]        sq_reg, sq_next;
    logic [EXP_W-1:0]      exp_reg, exp_next;

    logic [VALUE_BITS-1:0] pend_prime_reg, pend_prime_next;
    logic [EXP_W-1:0]      pend_exp_reg, pend_exp_next;
    logic                  pend_last_reg, pend_last_next;
    logic                  pend_inv_reg, pend_inv_next;

    logic [VALUE_BITS-1:0] prime_reg, prime_next;
    logic [EXP_W-1:0]      exponent_reg, exponent_next;
    logic                  last_reg, last_next;
    logic                  invalid_reg, invalid_next;

    logic [VALUE_BITS-1:0] value;
    logic                  in_fire;
    logic                  out_fire;
    logic                  out_free;
    logic                  sq_fits;

    logic                  dv_start;
    logic [VALUE_BITS-1:0] dv_dividend;
    logic                  dv_done;
    logic [VALUE_BITS-1:0] dv_quot;
    logic [VALUE_BITS-1:0] dv_rem;

    assign value    = number[VALUE_BITS-1:0];
    assign in_ready = (state_reg == ST_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid_reg && out_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign sq_fits  = (sq_reg <= SQW'(rem_reg));

    pf_divider #(
        .VALUE_BITS (VALUE_BITS)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (dv_start),
        .dividend  (dv_dividend),
        .divisor   (div_reg),
        .done      (dv_done),
        .quotient  (dv_quot),
        .remainder (dv_rem)
    );

    always_comb
    begin
        dv_start    = 1'b0;
        dv_dividend = rem_reg;
        if (state_reg == ST_CHECK && sq_fits)
        begin
            dv_start = 1'b1;
        end
        else if (state_reg == ST_DIV && dv_done && dv_rem == '0)
        begin
            dv_start    = 1'b1;
            dv_dividend = dv_quot;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        out_valid_next  = out_valid_reg;
        rem_next        = rem_reg;
        div_next        = div_reg;
        sq_next         = sq_reg;
        exp_next        = exp_reg;
        pend_prime_next = pend_prime_reg;
        pend_exp_next   = pend_exp_reg;
        pend_last_next  = pend_last_reg;
        pend_inv_next   = pend_inv_reg;
        prime_next      = prime_reg;
        exponent_next   = exponent_reg;
        last_next       = last_reg;
        invalid_next    = invalid_reg;

        if (out_fire)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (value < VALUE_BITS'(FIRST_DIVISOR))
                    begin
                        pend_prime_next = '0;
                        pend_exp_next   = '0;
                        pend_last_next  = 1'b1;
                        pend_inv_next   = 1'b1;
                        state_next      = ST_EMIT;
                    end
                    else
                    begin
                        rem_next   = value;
                        div_next   = VALUE_BITS'(FIRST_DIVISOR);
                        sq_next    = SQW'(FIRST_DIVISOR * FIRST_DIVISOR);
                        exp_next   = '0;
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK:
            begin
                state_next = sq_fits ? ST_DIV : ST_TAIL;
            end
            ST_DIV:
            begin
                if (dv_done)
                begin
                    if (dv_rem == '0)
                    begin
                        rem_next = dv_quot;
                        exp_next = exp_reg + 1'b1;
                    end
                    else if (exp_reg != '0)
                    begin
                        pend_prime_next = div_reg;
                        pend_exp_next   = exp_reg;
                        pend_last_next  = (rem_reg == VALUE_BITS'(1));
                        pend_inv_next   = 1'b0;
                        state_next      = ST_EMIT;
                    end
                    else
                    begin
                        state_next = ST_NEXT;
                    end
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    prime_next     = pend_prime_reg;
                    exponent_next  = pend_exp_reg;
                    last_next      = pend_last_reg;
                    invalid_next   = pend_inv_reg;
                    state_next     = pend_last_reg ? ST_IDLE : ST_NEXT;
                end
            end
            ST_NEXT:
            begin
                sq_next    = sq_reg + SQW'({div_reg, 1'b1});
                div_next   = div_reg + 1'b1;
                exp_next   = '0;
                state_next = ST_CHECK;
            end
            ST_TAIL:
            begin
                if (rem_reg > VALUE_BITS'(1))
                begin
                    pend_prime_next = rem_reg;
                    pend_exp_next   = EXP_W'(1);
                    pend_last_next  = 1'b1;
                    pend_inv_next   = 1'b0;
                    state_next      = ST_EMIT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg        <= rem_next;
        div_reg        <= div_next;
        sq_reg         <= sq_next;
        exp_reg        <= exp_next;
        pend_prime_reg <= pend_prime_next;
        pend_exp_reg   <= pend_exp_next;
        pend_last_reg  <= pend_last_next;
        pend_inv_reg   <= pend_inv_next;
        prime_reg      <= prime_next;
        exponent_reg   <= exponent_next;
        last_reg       <= last_next;
        invalid_reg    <= invalid_next;
    end

    assign out_valid = out_valid_reg;
    assign prime     = NUMBER_W'(prime_reg);
    assign exponent  = exponent_reg;
    assign last      = last_reg;
    assign invalid   = invalid_reg;

`ifndef SYNTH
    a_invalid_alone: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && invalid_reg |-> last_reg && prime_reg == '0 && exponent_reg == '0)
        else $error("invalid result carries factor data");
    a_factor_sane: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !invalid_reg |-> prime_reg >= VALUE_BITS'(FIRST_DIVISOR)
                                          && exponent_reg != '0)
        else $error("factor result with bad prime or exponent");
    a_div_start_state: assert property (@(posedge clk) disable iff (!rst_n)
        dv_start |-> (state_reg == ST_CHECK || state_reg == ST_DIV))
        else $error("divider started outside trial states");
    a_sq_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CHECK |-> sq_reg == SQW'(div_reg) * SQW'(div_reg))
        else $error("square register out of step with divisor");
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !in_ready)
        else $error("ready held after accepting an item");
`endif

endmodule

// ===== rtl/pf_divider.sv =====
// Shared restoring divider, one quotient bit per cycle.
// Depends on pf_pkg for the default width.
module pf_divider
    import pf_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [VALUE_BITS-1:0] dividend,
    input  logic [VALUE_BITS-1:0] divisor,
    output logic                  done,
    output logic [VALUE_BITS-1:0] quotient,
    output logic [VALUE_BITS-1:0] remainder
);

    localparam int CW = $clog2(VALUE_BITS + 1);

    logic                  run_reg, run_next;
    logic                  done_reg, done_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic [VALUE_BITS-1:0] q_reg, q_next;
    logic [VALUE_BITS-1:0] r_reg, r_next;
    logic [VALUE_BITS-1:0] d_reg, d_next;
    logic [VALUE_BITS:0]   shifted;
    logic [VALUE_BITS:0]   trial;

    assign shifted = {r_reg, q_reg[VALUE_BITS-1]};
    assign trial   = shifted - {1'b0, d_reg};

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = CW'(VALUE_BITS);
            q_next   = dividend;
            r_next   = '0;
            d_next   = divisor;
        end
        else if (run_reg)
        begin
            if (!trial[VALUE_BITS])
            begin
                r_next = trial[VALUE_BITS-1:0];
                q_next = {q_reg[VALUE_BITS-2:0], 1'b1};
            end
            else
            begin
                r_next = shifted[VALUE_BITS-1:0];
                q_next = {q_reg[VALUE_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done      = done_reg;
    assign quotient  = q_reg;
    assign remainder = r_reg;

`ifndef SYNTH
    a_done_rem_small: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && (d_reg != '0) |-> (r_reg < d_reg))
        else $error("divider remainder not below divisor");
    a_done_one_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("divider done held for more than one cycle");
    a_run_count: assert property (@(posedge clk) disable iff (!rst_n)
        run_reg |-> (cnt_reg != '0))
        else $error("divider running with zero count");
`endif

endmodule
